@@ hw/rtl/ascl_pkg.sv @@
// Shared types, sizes and codes of the ADC scan channel list.
package ascl_pkg;

    localparam int DEPTH        = 16;
    localparam int CHANNEL_BITS = 5;
    localparam int IDX_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W        = $clog2(DEPTH + 1);

    typedef logic [1:0]              t_cmd;
    typedef logic [1:0]              t_status;
    typedef logic [4:0]              t_chan_field;
    typedef logic [4:0]              t_count_field;
    typedef logic [CHANNEL_BITS-1:0] t_chan;
    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [CNT_W-1:0]        t_cnt;

    localparam t_cmd CMD_CLEAR      = 2'd0;
    localparam t_cmd CMD_REGISTER   = 2'd1;
    localparam t_cmd CMD_UNREGISTER = 2'd2;
    localparam t_cmd CMD_NEXT       = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_EMPTY     = 2'd2;
    localparam t_status ST_NOT_FOUND = 2'd3;

    localparam t_chan GROUND_CODE = {CHANNEL_BITS{1'b1}};
    localparam t_cnt  CNT_FULL    = t_cnt'(DEPTH);

endpackage

@@ hw/rtl/adc_scan_channel_list_unit.sv @@
// Top level of the ADC scan channel list: table, cursor and command sequencer.
//
// The block keeps a table of ADC multiplexer channel codes that is scanned round robin.
// The input channel (i_in_valid, o_in_stall, i_cmd, i_channel_in) takes one command item
// at a time: clear, register, unregister or next. The output channel (o_out_valid,
// i_out_stall, o_status, o_channel_out, o_entry_count) returns one result item for each.
// A command is decoded in the cycle after it is taken, and its result is loaded into the output
// register from the finishing state once that register is free. Next reduces the cursor
// modulo the entry count by repeated subtraction in one subtract and compare unit.
// Unregister runs a search that compares one table entry a cycle, then a shift that moves one
// entry down a cycle through the one read port and the one write port of the table.
// o_in_stall is high from the cycle after an item is taken until the sequencer is idle.
// A finished result waits in the output register while i_out_stall is high, and the next
// item is taken meanwhile; that item's result waits until the register is free.
// Synchronous reset empties the table, zeroes the cursor and drops the output register.
module adc_scan_channel_list_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  ascl_pkg::t_cmd             i_cmd,
    input  ascl_pkg::t_chan_field      i_channel_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output ascl_pkg::t_status          o_status,
    output ascl_pkg::t_chan_field      o_channel_out,
    output ascl_pkg::t_count_field     o_entry_count
);
    import ascl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_MOD    = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0] r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    t_chan      r_ch, n_ch;
    t_cnt       r_count, n_count;
    t_idx       r_cursor, n_cursor;
    t_idx       r_idx, n_idx;
    t_idx       r_pos, n_pos;
    t_cnt       r_mod, n_mod;
    t_status    r_status, n_status;
    t_chan      r_chan, n_chan;
    logic       r_out_valid, n_out_valid;
    t_status    r_out_status, n_out_status;
    t_chan      r_out_chan, n_out_chan;
    t_cnt       r_out_count, n_out_count;

    t_chan      r_table [DEPTH];
    t_idx       rd_addr;
    t_chan      r_rd_data;
    logic       we;
    t_idx       waddr;
    t_chan      wdata;
    t_cnt       idx_nxt_cnt;
    t_cnt       rd_nxt_cnt;

    assign idx_nxt_cnt = t_cnt'(r_idx) + t_cnt'(1);
    assign rd_nxt_cnt  = t_cnt'(n_idx) + t_cnt'(1);

    // The table read is registered, addressed by the next state, so its data is ready when that state begins.
    always_comb begin
        case (n_state)
            S_SHIFT: rd_addr = t_idx'(rd_nxt_cnt);
            S_MOD:   rd_addr = n_mod[IDX_W-1:0];
            default: rd_addr = n_idx;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_ch         = r_ch;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_mod        = r_mod;
        n_status     = r_status;
        n_chan       = r_chan;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_chan   = r_out_chan;
        n_out_count  = r_out_count;
        we           = 1'b0;
        waddr        = r_idx;
        wdata        = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_cmd;
                    n_ch    = i_channel_in[CHANNEL_BITS-1:0];
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_chan   = '0;
                n_state  = S_FIN;
                case (r_cmd)
                    CMD_CLEAR: begin
                        n_count  = '0;
                        n_cursor = '0;
                    end
                    CMD_REGISTER: begin
                        if (r_count == CNT_FULL) begin
                            n_status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            waddr   = r_count[IDX_W-1:0];
                            wdata   = r_ch;
                            n_count = r_count + t_cnt'(1);
                        end
                    end
                    CMD_UNREGISTER: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_idx   = '0;
                            n_state = S_SEARCH;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_mod   = t_cnt'(r_cursor) + t_cnt'(1);
                            n_state = S_MOD;
                        end
                    end
                endcase
            end
            S_SEARCH: begin
                if (r_rd_data == r_ch) begin
                    n_pos   = r_idx;
                    n_state = S_SHIFT;
                end else if (idx_nxt_cnt == r_count) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end else begin
                    n_idx = t_idx'(idx_nxt_cnt);
                end
            end
            S_SHIFT: begin
                we    = 1'b1;
                waddr = r_idx;
                if (idx_nxt_cnt < r_count) begin
                    wdata = r_rd_data;
                    n_idx = t_idx'(idx_nxt_cnt);
                end else begin
                    wdata   = GROUND_CODE;
                    n_count = r_count - t_cnt'(1);
                    if (r_cursor == r_pos && r_count != t_cnt'(1)) begin
                        if (r_pos == '0) begin
                            n_cursor = t_idx'(r_count - t_cnt'(2));
                        end else begin
                            n_cursor = r_pos - t_idx'(1);
                        end
                    end
                    n_state = S_FIN;
                end
            end
            S_MOD: begin
                if (r_mod >= r_count) begin
                    n_mod = r_mod - r_count;
                end else begin
                    n_cursor = r_mod[IDX_W-1:0];
                    n_chan   = r_rd_data;
                    n_state  = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_chan   = r_chan;
                    n_out_count  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_ch         <= n_ch;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_mod        <= n_mod;
        r_status     <= n_status;
        r_chan       <= n_chan;
        r_out_status <= n_out_status;
        r_out_chan   <= n_out_chan;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_table[waddr] <= wdata;
        end
        r_rd_data <= r_table[rd_addr];
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_channel_out = t_chan_field'(r_out_chan);
    assign o_entry_count = t_count_field'(r_out_count);

    // The entry count never exceeds the table depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count above table depth");

    // Once an item is taken, no further item is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while busy");

    // The shift pass stays inside the used part of the table.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (t_cnt'(r_idx) < r_count))
        else $error("shift index beyond entry count");

    // The modulo reduction never runs on an empty table.
    a_mod_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_count != '0))
        else $error("cursor reduction with empty table");

    // A result item is loaded only when the sequencer finishes a command.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || !i_out_stall) && (r_state != S_FIN) |=> !o_out_valid)
        else $error("result item without finished command");

endmodule

@@ tb/adc_scan_channel_list_unit_checker.sv @@
// Result predictor and comparator that watches both channels of the ADC scan channel list.
module adc_scan_channel_list_unit_checker
    import ascl_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_stall,
    input  t_cmd         i_cmd,
    input  t_chan_field  i_channel_in,
    input  logic         i_out_valid,
    input  logic         i_out_stall,
    input  t_status      i_status,
    input  t_chan_field  i_channel_out,
    input  t_count_field i_entry_count,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        t_status      status;
        t_chan_field  chan;
        t_count_field count;
    } t_scan_result;

    t_chan        slots [DEPTH];
    int           used;
    int           cursor;
    t_scan_result results_due [$];
    int           mismatches;

    function automatic void wipe_list();
        for (int k = 0; k < DEPTH; k++) begin
            slots[k] = GROUND_CODE;
        end
        used   = 0;
        cursor = 0;
    endfunction

    function automatic t_scan_result apply_command(input t_cmd cmd, input t_chan_field ch_in);
        t_scan_result r;
        t_chan        ch;
        int           pos;
        r.status = ST_OK;
        r.chan   = '0;
        ch       = t_chan'(ch_in);
        case (cmd)
            CMD_CLEAR: begin
                wipe_list();
            end
            CMD_REGISTER: begin
                if (used >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slots[used] = ch;
                    used++;
                end
            end
            CMD_UNREGISTER: begin
                if (used == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    pos = -1;
                    for (int k = 0; k < used; k++) begin
                        if (pos < 0 && slots[k] == ch) begin
                            pos = k;
                        end
                    end
                    if (pos < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (int k = pos; k < used - 1; k++) begin
                            slots[k] = slots[k + 1];
                        end
                        used--;
                        slots[used] = GROUND_CODE;
                        // The cursor steps back only when its own entry was removed.
                        if (cursor == pos && used != 0) begin
                            cursor = (used + cursor - 1) % used;
                        end
                    end
                end
            end
            default: begin
                if (used == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    cursor = (cursor + 1) % used;
                    r.chan = t_chan_field'(slots[cursor]);
                end
            end
        endcase
        r.count = t_count_field'(used);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result want;
        if (!i_rst_n) begin
            wipe_list();
            results_due.delete();
            mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    $error("result item with no command waiting: status %0d channel %0d count %0d",
                           i_status, i_channel_out, i_entry_count);
                    mismatches++;
                end else begin
                    want = results_due.pop_front();
                    if (i_status !== want.status) begin
                        $error("status expected %0d actual %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_channel_out !== want.chan) begin
                        $error("channel_out expected %0d actual %0d", want.chan, i_channel_out);
                        mismatches++;
                    end
                    if (i_entry_count !== want.count) begin
                        $error("entry_count expected %0d actual %0d", want.count,
                               i_entry_count);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(apply_command(i_cmd, i_channel_in));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= results_due.size();
    end

    initial begin
        mismatches   = 0;
        used         = 0;
        cursor       = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

endmodule

@@ tb/adc_scan_channel_list_unit_test.sv @@
// Stimulus, clock, reset and verdict for the ADC scan channel list testbench.
module adc_scan_channel_list_unit_test;
    import ascl_pkg::*;

    localparam int RANDOM_ITEMS = 1050;
    localparam int CYCLE_LIMIT  = 900000;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_in_valid;
    logic         o_in_stall;
    t_cmd         i_cmd;
    t_chan_field  i_channel_in;
    logic         o_out_valid;
    logic         i_out_stall;
    t_status      o_status;
    t_chan_field  o_channel_out;
    t_count_field o_entry_count;
    int           fail_count;
    int           pending;
    int           cycles;
    int           quiet_left;
    t_chan_field  live_chans [$];

    adc_scan_channel_list_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_channel_in  (i_channel_in),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_channel_out (o_channel_out),
        .o_entry_count (o_entry_count)
    );

    adc_scan_channel_list_unit_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_channel_in  (i_channel_in),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_channel_out (o_channel_out),
        .i_entry_count (o_entry_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic int idle_cycles();
        int roll;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            quiet_left = $urandom_range(30, 120);
            return 0;
        end
        if (roll < 75) begin
            return 0;
        end
        if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic issue(input t_cmd cmd, input t_chan_field ch);
        int gap;
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_channel_in <= ch;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (cmd == CMD_CLEAR) begin
            live_chans.delete();
        end else if (cmd == CMD_REGISTER) begin
            live_chans.push_back(ch);
            if (live_chans.size() > DEPTH) begin
                void'(live_chans.pop_front());
            end
        end
        gap = idle_cycles();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver stalls: short bursts mostly, a few long ones, and free stretches, mostly short, now and then long.
    initial begin
        int free_len;
        int stall_len;
        i_out_stall <= 1'b0;
        forever begin
            free_len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 200)
                                                    : $urandom_range(1, 8);
            repeat (free_len) @(posedge i_clk);
            stall_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
            i_out_stall <= 1'b1;
            repeat (stall_len) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    initial begin
        int          phase;
        int          roll;
        int          pick;
        t_cmd        cmd;
        t_chan_field ch;
        cycles       <= 0;
        quiet_left   = 0;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= CMD_CLEAR;
        i_channel_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table cases, then the cursor cases of unregister.
        issue(CMD_NEXT, 5'd0);
        issue(CMD_UNREGISTER, 5'd0);
        issue(CMD_REGISTER, 5'd31);
        issue(CMD_REGISTER, 5'd0);
        issue(CMD_REGISTER, 5'd21);
        issue(CMD_NEXT, 5'd31);
        issue(CMD_UNREGISTER, 5'd0);
        issue(CMD_UNREGISTER, 5'd10);
        issue(CMD_NEXT, 5'd0);
        issue(CMD_UNREGISTER, 5'd31);
        issue(CMD_NEXT, 5'd0);
        issue(CMD_UNREGISTER, 5'd21);
        // Fill the table to the last slot and one more.
        for (int k = 0; k <= DEPTH; k++) begin
            issue(CMD_REGISTER, t_chan_field'((k * 11) ^ 5'h15));
        end
        issue(CMD_NEXT, 5'd0);
        issue(CMD_CLEAR, 5'd31);

        phase = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                phase = $urandom_range(0, 2);
            end
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            roll = $urandom_range(0, 99);
            case (phase)
                0:       cmd = (roll < 65) ? CMD_REGISTER : (roll < 80) ? CMD_UNREGISTER :
                               (roll < 98) ? CMD_NEXT : CMD_CLEAR;
                1:       cmd = (roll < 15) ? CMD_REGISTER : (roll < 75) ? CMD_UNREGISTER :
                               (roll < 98) ? CMD_NEXT : CMD_CLEAR;
                default: cmd = (roll < 25) ? CMD_REGISTER : (roll < 50) ? CMD_UNREGISTER :
                               (roll < 98) ? CMD_NEXT : CMD_CLEAR;
            endcase
            ch = t_chan_field'($urandom_range(0, 31));
            if (live_chans.size() != 0) begin
                pick = $urandom_range(0, live_chans.size() - 1);
                if (cmd == CMD_UNREGISTER && $urandom_range(0, 9) < 7) begin
                    ch = live_chans[pick];
                    live_chans.delete(pick);
                end else if (cmd == CMD_REGISTER && $urandom_range(0, 9) < 2) begin
                    ch = live_chans[pick];
                end
            end
            issue(cmd, ch);
        end

        drain_results();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
